>>> rtl/jses_pkg.sv
// Shared types, character codes and helper functions of the JSON string escaper.
// Used by jses_front, jses_fifo, jses_back and json_string_escaper_utf8_check.
// No dependencies.
`default_nettype none

package jses_pkg;

  localparam int unsigned QueueDepth = 4;

  // Character codes
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLowU   = 8'h75;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowD   = 8'h64;
  localparam logic [7:0] ChLowB   = 8'h62;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChHexA   = 8'h57;  // 'a' less ten
  localparam logic [7:0] CtlBs    = 8'h08;
  localparam logic [7:0] CtlTab   = 8'h09;
  localparam logic [7:0] CtlLf    = 8'h0A;
  localparam logic [7:0] CtlFf    = 8'h0C;
  localparam logic [7:0] CtlCr    = 8'h0D;
  localparam logic [7:0] PrintMin = 8'h20;

  // Code point limits
  localparam logic [20:0] CpMax    = 21'h10FFFF;
  localparam logic [20:0] CpSurLo  = 21'h00D800;
  localparam logic [20:0] CpSurHi  = 21'h00DFFF;
  localparam logic [20:0] CpMin2   = 21'h000080;
  localparam logic [20:0] CpMin3   = 21'h000800;
  localparam logic [20:0] CpMin4   = 21'h010000;

  typedef enum logic [1:0] {
    TK_RAW,   // byte as it is
    TK_ESC,   // backslash, then byte
    TK_HEX,   // \u00 and two hex digits of byte
    TK_REPL   // \ufffd
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] chr;
    logic       last;
  } tok_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FEED,
    S_FRESH,
    S_DRAIN_REPL,
    S_DRAIN_OK,
    S_CLOSE,
    S_END
  } front_state_e;

  typedef enum logic [1:0] {
    RET_FRESH,
    RET_AFTER,
    RET_CLOSE
  } ret_e;

  // Length of the sequence a lead byte opens, zero for a non-lead byte
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] n;
    if (b[7:5] == 3'b110) begin
      n = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      n = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      n = 3'd4;
    end else begin
      n = 3'd0;
    end
    return n;
  endfunction

  // Reject overlong forms, surrogates and values past the last code point
  function automatic logic seq_ok(input logic [7:0] h0, input logic [7:0] h1,
                                  input logic [7:0] h2, input logic [7:0] c,
                                  input logic [2:0] n);
    logic [20:0] cp;
    logic        ok;
    case (n)
      3'd2: begin
        cp = {10'd0, h0[4:0], c[5:0]};
        ok = (cp >= CpMin2);
      end
      3'd3: begin
        cp = {5'd0, h0[3:0], h1[5:0], c[5:0]};
        ok = (cp >= CpMin3) && !((cp >= CpSurLo) && (cp <= CpSurHi));
      end
      default: begin
        cp = {h0[2:0], h1[5:0], h2[5:0], c[5:0]};
        ok = (cp >= CpMin4) && (cp <= CpMax);
      end
    endcase
    return ok;
  endfunction

  // Classify a byte below 0x80 into its escape token
  function automatic tok_t esc_tok(input logic [7:0] c);
    tok_t t;
    t.last = 1'b0;
    t.kind = TK_ESC;
    t.chr  = c;
    if (c == ChQuote || c == ChBslash) begin
      t.kind = TK_ESC;
    end else if (c >= PrintMin) begin
      t.kind = TK_RAW;
    end else if (c == CtlBs) begin
      t.chr = ChLowB;
    end else if (c == CtlFf) begin
      t.chr = ChLowF;
    end else if (c == CtlLf) begin
      t.chr = ChLowN;
    end else if (c == CtlCr) begin
      t.chr = ChLowR;
    end else if (c == CtlTab) begin
      t.chr = ChLowT;
    end else begin
      t.kind = TK_HEX;
    end
    return t;
  endfunction

  function automatic logic [2:0] tok_len(input tok_kind_e k);
    logic [2:0] n;
    case (k)
      TK_RAW:  n = 3'd1;
      TK_ESC:  n = 3'd2;
      default: n = 3'd6;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? (ChZero + {4'd0, v}) : (ChHexA + {4'd0, v});
  endfunction

  // Byte number k of the text a token stands for
  function automatic logic [7:0] tok_byte(input tok_t t, input logic [2:0] k);
    logic [7:0] b;
    case (t.kind)
      TK_RAW: b = t.chr;
      TK_ESC: b = (k == 3'd0) ? ChBslash : t.chr;
      TK_HEX: begin
        case (k)
          3'd0:    b = ChBslash;
          3'd1:    b = ChLowU;
          3'd2:    b = ChZero;
          3'd3:    b = ChZero;
          3'd4:    b = hex_char(t.chr[7:4]);
          default: b = hex_char(t.chr[3:0]);
        endcase
      end
      default: begin
        case (k)
          3'd0:    b = ChBslash;
          3'd1:    b = ChLowU;
          3'd5:    b = ChLowD;
          default: b = ChLowF;
        endcase
      end
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/json_string_escaper_utf8_check.sv
// JSON string escaper with UTF-8 checking: input string bytes in, quoted and
// escaped JSON text out. Depends on jses_pkg, jses_front, jses_fifo, jses_back.
//
// Input channel s_axis_*: one beat per string byte. tuser[0] says the beat
// carries a byte (clear for an empty-string framing beat), tuser[1] opens the
// string with a quote, tlast flushes any held partial sequence and closes it.
// Output channel m_axis_*: one beat per byte of JSON text; tlast marks the
// final byte caused by one input beat. A beat that causes no text gives none.
// The front end takes a beat, issues the token of a plain byte and ends the
// beat, with a further step for the closing quote, for each replacement
// character of a rejected held sequence, for each byte of a completed
// multi-byte sequence, and for resending the byte after a broken one. The
// back end sends one byte a cycle while the output is not stalled: one byte
// of text for a plain byte, two for a short escape, six for a \u escape. The
// slower of the two sets the rate; the token queue between them lets each
// run on while the other waits.
// Reset clears the held sequence, the queue and the output stage. When the
// receiver holds tready low the last byte stays registered, the queue fills,
// and then s_axis_tready drops until space frees up.
`default_nettype none

module json_string_escaper_utf8_check #(
  parameter int unsigned QueueDepth = jses_pkg::QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic [1:0] s_axis_tuser_i,   // [0] has_byte, [1] first_of_string
  input  wire logic       s_axis_tlast_i,   // last_of_string
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic            m_axis_tlast_o    // last_out
);

  logic           push;
  jses_pkg::tok_t push_data;
  logic           full;
  logic           pop;
  jses_pkg::tok_t head;
  logic           head_valid;

  jses_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i),
    .in_has_i    (s_axis_tuser_i[0]),
    .in_first_i  (s_axis_tuser_i[1]),
    .in_last_i   (s_axis_tlast_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  jses_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .valid_o     (head_valid)
  );

  jses_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

>>> rtl/jses_front.sv
// Front end of the escaper: accepts string items, tracks held UTF-8 bytes and
// issues at most one escape token per cycle, stalling while the queue is full.
// Depends on jses_pkg.
`default_nettype none

module jses_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [7:0]     in_byte_i,
  input  wire logic           in_has_i,
  input  wire logic           in_first_i,
  input  wire logic           in_last_i,
  output logic                push_o,
  output jses_pkg::tok_t      push_data_o,
  input  wire logic           full_i
);

  jses_pkg::front_state_e state_q, state_d;
  jses_pkg::ret_e         ret_q, ret_d;
  logic [7:0]             byte_q, byte_d;
  logic                   has_q, has_d;
  logic                   last_q, last_d;
  logic [7:0]             held_q [3];
  logic [1:0]             held_cnt_q, held_cnt_d;
  logic [2:0]             cnt_q, cnt_d;
  logic [1:0]             idx_q, idx_d;
  logic                   pend_valid_q;
  jses_pkg::tok_t         pend_q;

  logic                   held_we;
  logic [1:0]             held_wi;
  logic                   gen;
  jses_pkg::tok_t         gen_tok;
  logic                   can_take;
  logic                   adv;
  logic                   after_go;
  logic [1:0]             after_h;
  logic                   do_fresh;
  logic                   is_cont;
  logic [2:0]             lead_n;
  logic                   seq_done;
  logic                   seq_good;
  logic [7:0]             held_sel;
  jses_pkg::tok_t         quote_tok;
  jses_pkg::tok_t         repl_tok;

  assign can_take  = !pend_valid_q || !full_i;
  assign is_cont   = (byte_q[7:6] == 2'b10);
  assign lead_n    = (jses_pkg::seq_len(held_q[0]) == 3'd0) ? 3'd2
                                                            : jses_pkg::seq_len(held_q[0]);
  assign seq_done  = (held_cnt_q == 2'd3) || (({1'b0, held_cnt_q} + 3'd1) >= lead_n);
  assign seq_good  = jses_pkg::seq_ok(held_q[0], held_q[1], held_q[2], byte_q, lead_n);
  assign quote_tok = '{kind: jses_pkg::TK_RAW, chr: jses_pkg::ChQuote, last: 1'b0};
  assign repl_tok  = '{kind: jses_pkg::TK_REPL, chr: byte_q, last: 1'b0};

  always_comb begin
    case (idx_q)
      2'd0:    held_sel = held_q[0];
      2'd1:    held_sel = held_q[1];
      2'd2:    held_sel = held_q[2];
      default: held_sel = byte_q;
    endcase
    if (idx_q == held_cnt_q) begin
      held_sel = byte_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    byte_d     = byte_q;
    has_d      = has_q;
    last_d     = last_q;
    held_cnt_d = held_cnt_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    held_we    = 1'b0;
    held_wi    = 2'd0;
    gen        = 1'b0;
    gen_tok    = quote_tok;
    after_go   = 1'b0;
    after_h    = held_cnt_q;
    do_fresh   = 1'b0;
    in_ready_o = 1'b0;

    case (state_q)
      jses_pkg::S_IDLE: begin
        in_ready_o = can_take;
        if (in_valid_i && can_take) begin
          byte_d  = in_byte_i;
          has_d   = in_has_i;
          last_d  = in_last_i;
          state_d = jses_pkg::S_FEED;
          // opening quote drops whatever an unterminated string left held
          if (in_first_i) begin
            held_cnt_d = 2'd0;
            gen        = 1'b1;
          end
        end
      end
      jses_pkg::S_FEED: begin
        if (!has_q) begin
          after_go = 1'b1;
        end else if (held_cnt_q != 2'd0 && is_cont) begin
          if (seq_done) begin
            if (seq_good) begin
              state_d = jses_pkg::S_DRAIN_OK;
              idx_d   = 2'd0;
            end else begin
              state_d    = jses_pkg::S_DRAIN_REPL;
              cnt_d      = {1'b0, held_cnt_q} + 3'd1;
              ret_d      = jses_pkg::RET_AFTER;
              held_cnt_d = 2'd0;
            end
          end else begin
            held_we    = 1'b1;
            held_wi    = held_cnt_q;
            held_cnt_d = held_cnt_q + 2'd1;
            after_go   = 1'b1;
            after_h    = held_cnt_q + 2'd1;
          end
        end else if (held_cnt_q != 2'd0) begin
          // broken sequence: replace what is held, then treat the byte afresh
          state_d    = jses_pkg::S_DRAIN_REPL;
          cnt_d      = {1'b0, held_cnt_q};
          ret_d      = jses_pkg::RET_FRESH;
          held_cnt_d = 2'd0;
        end else begin
          do_fresh = 1'b1;
        end
      end
      jses_pkg::S_FRESH: begin
        do_fresh = 1'b1;
      end
      jses_pkg::S_DRAIN_REPL: begin
        gen     = 1'b1;
        gen_tok = repl_tok;
        cnt_d   = cnt_q - 3'd1;
        if (cnt_q == 3'd1) begin
          case (ret_q)
            jses_pkg::RET_FRESH: state_d = jses_pkg::S_FRESH;
            jses_pkg::RET_AFTER: begin
              after_go = 1'b1;
              after_h  = 2'd0;
            end
            default: state_d = jses_pkg::S_CLOSE;
          endcase
        end
      end
      jses_pkg::S_DRAIN_OK: begin
        gen     = 1'b1;
        gen_tok = '{kind: jses_pkg::TK_RAW, chr: held_sel, last: 1'b0};
        idx_d   = idx_q + 2'd1;
        if (idx_q == held_cnt_q) begin
          held_cnt_d = 2'd0;
          after_go   = 1'b1;
          after_h    = 2'd0;
        end
      end
      jses_pkg::S_CLOSE: begin
        gen     = 1'b1;
        state_d = jses_pkg::S_END;
      end
      jses_pkg::S_END: begin
        state_d = jses_pkg::S_IDLE;
      end
      default: begin
        state_d = jses_pkg::S_IDLE;
      end
    endcase

    if (do_fresh) begin
      if (!byte_q[7]) begin
        gen      = 1'b1;
        gen_tok  = jses_pkg::esc_tok(byte_q);
        after_go = 1'b1;
        after_h  = 2'd0;
      end else if (jses_pkg::seq_len(byte_q) == 3'd0) begin
        gen      = 1'b1;
        gen_tok  = repl_tok;
        after_go = 1'b1;
        after_h  = 2'd0;
      end else begin
        held_we    = 1'b1;
        held_wi    = 2'd0;
        held_cnt_d = 2'd1;
        after_go   = 1'b1;
        after_h    = 2'd1;
      end
    end

    // end of the byte's work: flush a truncated sequence and close if last
    if (after_go) begin
      if (last_q && after_h != 2'd0) begin
        state_d    = jses_pkg::S_DRAIN_REPL;
        cnt_d      = {1'b0, after_h};
        ret_d      = jses_pkg::RET_CLOSE;
        held_cnt_d = 2'd0;
      end else if (last_q) begin
        state_d = jses_pkg::S_CLOSE;
      end else begin
        state_d = jses_pkg::S_END;
      end
    end
  end

  // hold the newest token back one step so the last of an item can be marked
  assign adv    = (state_q == jses_pkg::S_END) ? can_take : (!gen || can_take);
  assign push_o = adv && pend_valid_q && (gen || state_q == jses_pkg::S_END);

  always_comb begin
    push_data_o      = pend_q;
    push_data_o.last = (state_q == jses_pkg::S_END);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= jses_pkg::S_IDLE;
      ret_q        <= jses_pkg::RET_FRESH;
      held_cnt_q   <= 2'd0;
      cnt_q        <= 3'd0;
      idx_q        <= 2'd0;
      pend_valid_q <= 1'b0;
    end else if (adv) begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      held_cnt_q <= held_cnt_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      if (gen) begin
        pend_valid_q <= 1'b1;
      end else if (state_q == jses_pkg::S_END) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q[0] <= 8'd0;
      held_q[1] <= 8'd0;
      held_q[2] <= 8'd0;
    end else if (adv && held_we) begin
      held_q[held_wi] <= byte_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q <= byte_d;
      has_q  <= has_d;
      last_q <= last_d;
      if (gen) begin
        pend_q <= gen_tok;
      end
    end
  end

`ifndef ASSERT_OFF
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == jses_pkg::S_IDLE |-> !pend_valid_q)
    else $error("token left pending while idle");
  a_held_is_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt_q != 2'd0 |-> held_q[0][7:6] == 2'b11)
    else $error("held sequence does not start with a lead byte");
  a_drain_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == jses_pkg::S_DRAIN_REPL |-> cnt_q != 3'd0)
    else $error("replacement drain with zero count");
`endif

endmodule

`default_nettype wire

>>> rtl/jses_fifo.sv
// Short token queue between the front and back ends of the escaper.
// Depends on jses_pkg for the token type.
`default_nettype none

module jses_fifo #(
  parameter int unsigned Depth = jses_pkg::QueueDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire jses_pkg::tok_t  push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output jses_pkg::tok_t       head_o,
  output logic                 valid_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  jses_pkg::tok_t  mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("token queue count past depth");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("token queue popped while empty");
`endif

endmodule

`default_nettype wire

>>> rtl/jses_back.sv
// Back end of the escaper: expands queued tokens into bytes, one a cycle
// unless stalled, through a registered output stage. Depends on jses_pkg.
`default_nettype none

module jses_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire jses_pkg::tok_t  head_i,
  input  wire logic            head_valid_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o
);

  logic [2:0] k_q;
  logic [2:0] len;
  logic       at_end;
  logic       load;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  assign len    = jses_pkg::tok_len(head_i.kind);
  assign at_end = (k_q == len - 3'd1);
  assign load   = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o  = load && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        k_q         <= at_end ? 3'd0 : k_q + 3'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= jses_pkg::tok_byte(head_i, k_q);
      out_last_q <= head_i.last && at_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

`ifndef ASSERT_OFF
  a_k_in_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> k_q < len)
    else $error("byte counter beyond token length");
  a_k_holds_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q != 3'd0 |-> head_valid_i)
    else $error("token left queue part way through expansion");
`endif

endmodule

`default_nettype wire

>>> test/jses_escape_check.sv
// Checker for the JSON string escaper: watches both stream channels, predicts
// the escaped text of every accepted input beat and compares it byte by byte.
// Depends on jses_pkg for character codes and code point limits.
`timescale 1ns / 1ps

module jses_escape_check (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  input  wire logic       s_axis_tready_i,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic [1:0] s_axis_tuser_i,   // [0] has_byte, [1] first_of_string
  input  wire logic       s_axis_tlast_i,   // last_of_string
  input  wire logic       m_axis_tvalid_i,
  input  wire logic       m_axis_tready_i,
  input  wire logic [7:0] m_axis_tdata_i,   // [7:0] out_byte
  input  wire logic       m_axis_tlast_i,   // last_out
  output int unsigned     errors_o,
  output int unsigned     pending_o
);

  localparam int unsigned MaxText = 25;
  localparam logic [7:0]  LowA    = 8'h61;

  typedef struct packed {
    logic [7:0] text;
    logic       fin;
  } text_beat_t;

  text_beat_t  text_q[$];
  logic [7:0]  held_seq [3];
  int unsigned held_n;
  int unsigned item_n;
  int unsigned miss_n;

  function automatic void emit(input logic [7:0] c);
    text_beat_t b;
    if (item_n < MaxText) begin
      b.text = c;
      b.fin  = 1'b0;
      text_q.push_back(b);
      item_n++;
    end
  endfunction

  function automatic void emit_repl();
    emit(jses_pkg::ChBslash);
    emit(jses_pkg::ChLowU);
    emit(jses_pkg::ChLowF);
    emit(jses_pkg::ChLowF);
    emit(jses_pkg::ChLowF);
    emit(jses_pkg::ChLowD);
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    return (v < 4'd10) ? jses_pkg::ChZero + 8'(v) : LowA + 8'(v - 4'd10);
  endfunction

  function automatic void escape_ascii(input logic [7:0] c);
    if (c == jses_pkg::ChQuote || c == jses_pkg::ChBslash) begin
      emit(jses_pkg::ChBslash);
      emit(c);
    end else if (c >= jses_pkg::PrintMin) begin
      emit(c);
    end else if (c == jses_pkg::CtlBs) begin
      emit(jses_pkg::ChBslash);
      emit(jses_pkg::ChLowB);
    end else if (c == jses_pkg::CtlFf) begin
      emit(jses_pkg::ChBslash);
      emit(jses_pkg::ChLowF);
    end else if (c == jses_pkg::CtlLf) begin
      emit(jses_pkg::ChBslash);
      emit(jses_pkg::ChLowN);
    end else if (c == jses_pkg::CtlCr) begin
      emit(jses_pkg::ChBslash);
      emit(jses_pkg::ChLowR);
    end else if (c == jses_pkg::CtlTab) begin
      emit(jses_pkg::ChBslash);
      emit(jses_pkg::ChLowT);
    end else begin
      emit(jses_pkg::ChBslash);
      emit(jses_pkg::ChLowU);
      emit(jses_pkg::ChZero);
      emit(jses_pkg::ChZero);
      emit(nibble_char(c[7:4]));
      emit(nibble_char(c[3:0]));
    end
  endfunction

  function automatic int unsigned lead_len(input logic [7:0] c);
    if (c[7:5] == 3'b110) return 2;
    if (c[7:4] == 4'b1110) return 3;
    if (c[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  // every held byte of a broken sequence turns into one replacement
  function automatic void drop_held();
    int unsigned k;
    for (k = 0; k < held_n && k < 3; k++) begin
      emit_repl();
    end
    held_n = 0;
  endfunction

  function automatic void close_seq(input int unsigned n, input logic [7:0] c);
    logic [20:0] cp;
    logic        ok;
    int unsigned k;
    case (n)
      2:       cp = {10'd0, held_seq[0][4:0], c[5:0]};
      3:       cp = {5'd0, held_seq[0][3:0], held_seq[1][5:0], c[5:0]};
      default: cp = {held_seq[0][2:0], held_seq[1][5:0], held_seq[2][5:0], c[5:0]};
    endcase
    ok = !((n == 2 && cp < jses_pkg::CpMin2) || (n == 3 && cp < jses_pkg::CpMin3) ||
           (n == 4 && cp < jses_pkg::CpMin4));
    if (cp > jses_pkg::CpMax || (cp >= jses_pkg::CpSurLo && cp <= jses_pkg::CpSurHi)) begin
      ok = 1'b0;
    end
    if (ok) begin
      for (k = 0; k + 1 < n && k < 3; k++) begin
        emit(held_seq[k]);
      end
      emit(c);
      held_n = 0;
    end else begin
      drop_held();
      emit_repl();
    end
  endfunction

  function automatic void feed_byte(input logic [7:0] c);
    int unsigned n;
    if (held_n > 0) begin
      if (c[7:6] == 2'b10) begin
        n = lead_len(held_seq[0]);
        if (n == 0 || held_n >= 3 || held_n + 1 >= n) begin
          close_seq((n == 0) ? 2 : n, c);
        end else begin
          held_seq[held_n] = c;
          held_n++;
        end
        return;
      end
      drop_held();
    end
    if (c < 8'h80) begin
      escape_ascii(c);
    end else if (lead_len(c) == 0) begin
      emit_repl();
    end else begin
      held_seq[0] = c;
      held_n = 1;
    end
  endfunction

  function automatic void predict_beat(input logic [7:0] c, input logic [1:0] user,
                                       input logic last);
    text_beat_t tail;
    item_n = 0;
    if (user[1]) begin
      held_n = 0;
      emit(jses_pkg::ChQuote);
    end
    if (user[0]) begin
      feed_byte(c);
    end
    if (last) begin
      drop_held();
      emit(jses_pkg::ChQuote);
    end
    if (item_n > 0) begin
      tail = text_q.pop_back();
      tail.fin = 1'b1;
      text_q.push_back(tail);
    end
  endfunction

  function automatic void check_text(input logic [7:0] c, input logic last);
    text_beat_t want;
    if (text_q.size() == 0) begin
      $error("out_byte: %02h arrived with nothing expected", c);
      miss_n++;
    end else begin
      want = text_q.pop_front();
      if (want.text !== c) begin
        $error("out_byte: expected %02h, got %02h", want.text, c);
        miss_n++;
      end
      if (want.fin !== last) begin
        $error("last_out: expected %0b, got %0b", want.fin, last);
        miss_n++;
      end
    end
  endfunction

  // outputs of this edge cannot stem from an input of the same edge: check first
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_q.delete();
      held_seq[0] = 8'h00;
      held_seq[1] = 8'h00;
      held_seq[2] = 8'h00;
      held_n      = 0;
      item_n      = 0;
      miss_n      = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        check_text(m_axis_tdata_i, m_axis_tlast_i);
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_beat(s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i);
      end
      errors_o  <= miss_n;
      pending_o <= text_q.size();
    end
  end

endmodule

>>> test/tb_top.sv
// Top of the JSON string escaper testbench: clock, reset, string stimulus
// and receiver stalls; jses_escape_check predicts and compares the text.
// Depends on jses_pkg, json_string_escaper_utf8_check and jses_escape_check.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ItemTarget  = 300;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 64;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_COIN,
    FLOW_SPARSE,
    FLOW_CHOKE
  } flow_e;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;  // [7:0] in_byte
  logic [1:0]  s_tuser  = 2'b00;  // [0] has_byte, [1] first_of_string
  logic        s_tlast  = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  int unsigned fail_n;
  int unsigned pending_n;

  int unsigned cycle_n    = 0;
  int unsigned sent_n     = 0;
  int unsigned burst_left = 0;
  int unsigned flow_left  = 0;
  logic [4:0]  flow_tick  = 5'd0;
  flow_e       flow_mode  = FLOW_FREE;
  logic [7:0]  word_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  json_string_escaper_utf8_check DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  jses_escape_check u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .errors_o        (fail_n),
    .pending_o       (pending_n)
  );

  // receiver: switch between free flow, coin tosses, sparse and long stalls
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_tready  <= 1'b0;
      flow_left <= 0;
      flow_tick <= 5'd0;
      flow_mode <= FLOW_FREE;
    end else begin
      flow_tick <= flow_tick + 5'd1;
      if (flow_left == 0) begin
        flow_mode <= flow_e'($urandom_range(0, 3));
        flow_left <= $urandom_range(4, 48);
      end else begin
        flow_left <= flow_left - 1;
      end
      case (flow_mode)
        FLOW_FREE:   m_tready <= 1'b1;
        FLOW_COIN:   m_tready <= 1'($urandom_range(0, 1));
        FLOW_SPARSE: m_tready <= (flow_tick[1:0] == 2'd0);
        default:     m_tready <= flow_tick[4];
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one beat, held until accepted; bursts of random length with idle gaps
  task automatic send_beat(input logic [7:0] c, input logic has, input logic open_f,
                           input logic close_f);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tuser  <= {open_f, has};
    s_tlast  <= close_f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_n++;
  endtask

  // hold the sender until every expected byte has come out
  task automatic settle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_n != 0) @(posedge clk);
  endtask

  function automatic void push_utf8(input logic [20:0] cp, input int unsigned n);
    case (n)
      1: word_q.push_back({1'b0, cp[6:0]});
      2: begin
        word_q.push_back({3'b110, cp[10:6]});
        word_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        word_q.push_back({4'b1110, cp[15:12]});
        word_q.push_back({2'b10, cp[11:6]});
        word_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        word_q.push_back({5'b11110, cp[20:18]});
        word_q.push_back({2'b10, cp[17:12]});
        word_q.push_back({2'b10, cp[11:6]});
        word_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  task automatic build_word();
    int unsigned len;
    int unsigned k;
    int unsigned pick;
    int unsigned n;
    int unsigned cut;
    logic [20:0] cp;
    word_q.delete();
    len = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
    for (k = 0; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        word_q.push_back(8'($urandom_range(8'h20, 8'h7F)));
      end else if (pick < 38) begin
        word_q.push_back(pick[0] ? jses_pkg::ChQuote : jses_pkg::ChBslash);
      end else if (pick < 48) begin
        word_q.push_back(8'($urandom_range(8'h01, 8'h1F)));
      end else if (pick < 58) begin
        push_utf8(21'($urandom_range(21'h80, 21'h7FF)), 2);
      end else if (pick < 68) begin
        cp = 21'($urandom_range(21'h800, 21'hFFFF));
        if (cp >= jses_pkg::CpSurLo && cp <= jses_pkg::CpSurHi) begin
          cp = cp - 21'h800;
        end
        push_utf8(cp, 3);
      end else if (pick < 78) begin
        push_utf8(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
      end else if (pick < 84) begin
        // overlong form
        n = $urandom_range(2, 4);
        push_utf8(21'($urandom_range(0, (n == 2) ? 21'h7F : (n == 3) ? 21'h7FF
                                                                        : 21'hFFFF)), n);
      end else if (pick < 87) begin
        push_utf8(21'($urandom_range(21'hD800, 21'hDFFF)), 3);
      end else if (pick < 90) begin
        push_utf8(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
      end else if (pick < 95) begin
        word_q.push_back(pick[0] ? 8'($urandom_range(8'h80, 8'hBF))
                                 : 8'($urandom_range(8'hF8, 8'hFF)));
      end else begin
        // sequence cut short
        n = $urandom_range(2, 4);
        push_utf8(21'($urandom_range(0, 21'h1FFFFF)), n);
        cut = $urandom_range(1, n - 1);
        repeat (cut) void'(word_q.pop_back());
      end
    end
  endtask

  task automatic send_word(input logic open_f, input logic close_f);
    int unsigned k;
    logic        split_open;
    logic        split_close;
    if (word_q.size() == 0) begin
      if ($urandom_range(0, 1) == 1) begin
        send_beat(8'($urandom_range(1, 255)), 1'b0, open_f, close_f);
      end else begin
        send_beat(8'($urandom_range(1, 255)), 1'b0, open_f, 1'b0);
        send_beat(8'($urandom_range(1, 255)), 1'b0, 1'b0, close_f);
      end
      return;
    end
    split_open  = open_f && ($urandom_range(0, 9) == 0);
    split_close = close_f && ($urandom_range(0, 9) == 0);
    if (split_open) begin
      send_beat(8'($urandom_range(1, 255)), 1'b0, 1'b1, 1'b0);
    end
    for (k = 0; k < word_q.size(); k++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_beat(8'($urandom_range(1, 255)), 1'b0, 1'b0, 1'b0);
      end
      send_beat(word_q[k], 1'b1, open_f && !split_open && k == 0,
                close_f && !split_close && k + 1 == word_q.size());
    end
    if (split_close) begin
      send_beat(8'($urandom_range(1, 255)), 1'b0, 1'b0, 1'b1);
    end
  endtask

  initial begin
    int unsigned word_n;
    int unsigned mode;
    int unsigned k;
    int unsigned noise_n;
    word_n = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty string in one beat
    send_beat(8'hA5, 1'b0, 1'b1, 1'b1);
    // quote, backslash, short escapes, a hex escape, stray bytes, overlong pair,
    // value past the last code point, broken sequence, truncation at the end
    send_beat(jses_pkg::ChQuote, 1'b1, 1'b1, 1'b0);
    send_beat(jses_pkg::ChBslash, 1'b1, 1'b0, 1'b0);
    send_beat(jses_pkg::CtlBs, 1'b1, 1'b0, 1'b0);
    send_beat(jses_pkg::CtlFf, 1'b1, 1'b0, 1'b0);
    send_beat(jses_pkg::CtlLf, 1'b1, 1'b0, 1'b0);
    send_beat(jses_pkg::CtlCr, 1'b1, 1'b0, 1'b0);
    send_beat(jses_pkg::CtlTab, 1'b1, 1'b0, 1'b0);
    send_beat(8'h01, 1'b1, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b0, 1'b0);
    send_beat(8'h80, 1'b1, 1'b0, 1'b0);
    send_beat(8'hC1, 1'b1, 1'b0, 1'b0);
    send_beat(8'hBF, 1'b1, 1'b0, 1'b0);
    send_beat(8'hF4, 1'b1, 1'b0, 1'b0);
    send_beat(8'h90, 1'b1, 1'b0, 1'b0);
    send_beat(8'h80, 1'b1, 1'b0, 1'b0);
    send_beat(8'h80, 1'b1, 1'b0, 1'b0);
    send_beat(8'hE2, 1'b1, 1'b0, 1'b0);
    send_beat(8'h82, 1'b1, 1'b0, 1'b0);
    send_beat(8'h20, 1'b1, 1'b0, 1'b0);
    send_beat(8'hF0, 1'b1, 1'b0, 1'b0);
    send_beat(8'h9F, 1'b1, 1'b0, 1'b1);
    // open a new string while a sequence is held, then the highest code point
    send_beat(8'hE2, 1'b1, 1'b1, 1'b0);
    send_beat(8'hF4, 1'b1, 1'b1, 1'b0);
    send_beat(8'h8F, 1'b1, 1'b0, 1'b0);
    send_beat(8'hBF, 1'b1, 1'b0, 1'b0);
    send_beat(8'hBF, 1'b1, 1'b0, 1'b1);
    settle();

    while (sent_n < ItemTarget) begin
      word_n++;
      if (word_n % 16 == 5) begin
        settle();
      end
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        noise_n = $urandom_range(1, 5);
        for (k = 0; k < noise_n; k++) begin
          send_beat(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
        end
      end else begin
        build_word();
        // drop the opening or the closing flag now and then
        send_word(mode != 1, mode != 2);
      end
    end

    settle();
    repeat (DrainCycles) @(posedge clk);
    if (fail_n == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
